// ----- sv/cri_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Climber ratchet interlock package
// Shared types, widths and reset values for the climber interlock block.
// ----------------------------------------------------------------------------
package cri_pkg;

    localparam int CFG_W   = 23;
    localparam int LIMIT_W = 23;
    localparam int GAIN_W  = 11;
    localparam int TIMER_W = 16;
    localparam int POWER_W = 12;

    localparam logic [GAIN_W-1:0]  FULL_POWER  = 11'd1024;
    localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;

    localparam logic [LIMIT_W-1:0] TOP_LIMIT_RST    = 23'd32500;
    localparam logic [LIMIT_W-1:0] BOTTOM_LIMIT_RST = 23'd1024;
    localparam logic [GAIN_W-1:0]  SLOW_GAIN_RST    = 11'd307;
    localparam logic [TIMER_W-1:0] DELAY_RST        = 16'd1000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TOP_LIMIT    = 2'd0,
        CFG_BOTTOM_LIMIT = 2'd1,
        CFG_SLOW_GAIN    = 2'd2,
        CFG_DELAY        = 2'd3
    } t_cfg_idx;

    // Request kinds. The unused code is treated like a stop.
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_CTRL = 2'd1,
        ACT_STOP = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MOVING = 2'd1,
        PH_MOVED  = 2'd2
    } t_phase;

    // Request presented to the ratchet state machine.
    typedef struct packed {
        logic    fire;
        t_action action;
        logic    pov;
        logic    power_nz;
        logic    both_stop;
    } t_ratchet_req;

    // Status returned by the ratchet state machine.
    typedef struct packed {
        logic homed_cur;
        logic hold;
        logic drive;
        logic solenoid;
        logic zero_enc;
        logic homed_next;
    } t_ratchet_stat;

endpackage
`default_nettype wire

// ----- sv/cri_power_gate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Climber power gate
// Maps one motor's buttons to signed power and blocks it at the limits.
// ----------------------------------------------------------------------------
module cri_power_gate #(
    parameter int POS_WIDTH = 24
) (
    input  wire logic                          i_up,
    input  wire logic                          i_down,
    input  wire logic [cri_pkg::GAIN_W-1:0]    i_mag,
    input  wire logic                          i_on_stop,
    input  wire logic signed [POS_WIDTH-1:0]   i_position,
    input  wire logic                          i_homed,
    input  wire logic [cri_pkg::LIMIT_W-1:0]   i_top_limit,
    input  wire logic [cri_pkg::LIMIT_W-1:0]   i_bottom_limit,
    output logic signed [cri_pkg::POWER_W-1:0] o_power
);
    import cri_pkg::*;

    localparam int CMP_W = (POS_WIDTH > LIMIT_W + 1) ? POS_WIDTH : LIMIT_W + 1;

    logic signed [POWER_W-1:0] raw_power;
    logic signed [CMP_W-1:0]   pos_ext;
    logic signed [CMP_W-1:0]   top_ext;
    logic signed [CMP_W-1:0]   bottom_ext;
    logic                      at_top;
    logic                      at_bottom;

    assign pos_ext    = CMP_W'(i_position);
    assign top_ext    = $signed(CMP_W'(i_top_limit));
    assign bottom_ext = $signed(CMP_W'(i_bottom_limit));
    assign at_top     = i_homed && (pos_ext >= top_ext);
    assign at_bottom  = i_homed && (pos_ext <= bottom_ext);

    always_comb begin
        if (i_up) begin
            raw_power = $signed(POWER_W'(i_mag));
        end else if (i_down) begin
            raw_power = -$signed(POWER_W'(i_mag));
        end else begin
            raw_power = '0;
        end

        o_power = raw_power;
        // Downward power stops at the switch or the soft bottom.
        if ((raw_power < 0) && (i_on_stop || at_bottom)) begin
            o_power = '0;
        end
        if ((raw_power > 0) && at_top) begin
            o_power = '0;
        end
    end

endmodule
`default_nettype wire

// ----- sv/cri_ratchet.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Climber ratchet state machine
// Holds the ratchet phase, timer, solenoid and homing latch.
// ----------------------------------------------------------------------------
module cri_ratchet (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cri_pkg::t_ratchet_req        i_req,
    input  wire logic [cri_pkg::TIMER_W-1:0]  i_delay,
    output cri_pkg::t_ratchet_stat            o_stat
);
    import cri_pkg::*;

    t_phase               r_phase,    n_phase;
    logic [TIMER_W-1:0]   r_timer,    n_timer;
    logic                 r_homed,    n_homed;
    logic                 r_solenoid, n_solenoid;
    logic                 hold;
    logic                 zero_enc;
    logic                 drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_homed    <= 1'b0;
            r_solenoid <= 1'b0;
        end else if (i_req.fire) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_homed    <= n_homed;
            r_solenoid <= n_solenoid;
        end
    end

    assign hold = r_homed && i_req.pov;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_homed    = r_homed;
        n_solenoid = r_solenoid;
        zero_enc   = 1'b0;
        drive      = 1'b0;

        case (i_req.action)
            ACT_TICK: begin
                if (r_timer != TIMER_MAX) begin
                    n_timer = r_timer + 1'b1;
                end
            end
            ACT_CTRL: begin
                if (!hold) begin
                    if (!i_req.power_nz) begin
                        n_phase    = PH_IDLE;
                        n_solenoid = 1'b0;
                    end else begin
                        case (r_phase)
                            PH_MOVING: begin
                                if (r_timer > i_delay) begin
                                    n_phase = PH_MOVED;
                                end
                            end
                            PH_MOVED: begin
                                n_phase = PH_MOVED;
                            end
                            default: begin
                                n_solenoid = 1'b1;
                                n_phase    = PH_MOVING;
                                n_timer    = '0;
                            end
                        endcase
                    end
                    drive = (n_phase != PH_MOVING);
                    if (!r_homed && i_req.both_stop) begin
                        n_homed  = 1'b1;
                        zero_enc = 1'b1;
                    end
                end
            end
            default: begin
                n_phase    = PH_IDLE;
                n_solenoid = 1'b0;
                drive      = 1'b1;
            end
        endcase
    end

    assign o_stat.homed_cur  = r_homed;
    assign o_stat.hold       = hold;
    assign o_stat.drive      = drive;
    assign o_stat.solenoid   = n_solenoid;
    assign o_stat.zero_enc   = zero_enc;
    assign o_stat.homed_next = n_homed;

    // Once homed, the latch never clears.
    a_homed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homed |=> r_homed)
        else $error("homed latch cleared");

    // The solenoid is only reversed while the ratchet is idle.
    a_solenoid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_solenoid |-> (r_phase == PH_IDLE))
        else $error("solenoid reversed outside idle phase");

    // Entering the moving phase restarts the opening timer.
    a_timer_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && (n_phase == PH_MOVING) && (r_phase != PH_MOVING))
        |=> (r_timer == '0))
        else $error("ratchet timer not restarted");

endmodule
`default_nettype wire

// ----- sv/climber_ratchet_interlock_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Climber ratchet interlock unit
// Drives two climber motors that share one ratchet solenoid.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the input channel (i_valid / o_stall) and each request
// yields exactly one result on the output channel (o_valid / i_stall).
// A request is a tick (advances the ratchet timer), a control sample (maps
// buttons to power, gates it at the limit switches and soft limits, runs the
// ratchet machine and the homing latch) or a stop (idles everything).
// The request is first captured in an input register; the gating and ratchet
// logic then settle combinationally and the result is written to the output
// register. One request per cycle is sustained while the receiver does not stall;
// the ratchet state register is the only loop.
// When the receiver stalls, the output register holds its result and the input
// register holds the next request; o_stall rises only when both are full.
// Synchronous reset returns the ratchet to idle with the solenoid reversed,
// clears the timer and the homed latch, empties both registers and loads the
// configuration registers with their default values.
// Configuration writes (i_cfg_we) take effect at once; the user must make them
// only while no request is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module climber_ratchet_interlock_unit #(
    parameter int POS_WIDTH = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [cri_pkg::CFG_W-1:0]     i_cfg_data,
    // Request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic                          i_port_up_button,
    input  wire logic                          i_port_down_button,
    input  wire logic                          i_star_up_button,
    input  wire logic                          i_star_down_button,
    input  wire logic                          i_slow_mode,
    input  wire logic                          i_pov_pressed,
    input  wire logic                          i_port_on_stop,
    input  wire logic                          i_star_on_stop,
    input  wire logic signed [POS_WIDTH-1:0]   i_port_position,
    input  wire logic signed [POS_WIDTH-1:0]   i_star_position,
    // Result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [cri_pkg::POWER_W-1:0] o_port_power,
    output logic signed [cri_pkg::POWER_W-1:0] o_star_power,
    output logic                               o_drive_update,
    output logic                               o_solenoid_open,
    output logic                               o_zero_encoders,
    output logic                               o_homed
);
    import cri_pkg::*;

    // Configuration registers.
    logic [LIMIT_W-1:0] r_top_limit;
    logic [LIMIT_W-1:0] r_bottom_limit;
    logic [GAIN_W-1:0]  r_slow_gain;
    logic [TIMER_W-1:0] r_delay;

    // Input register.
    logic                        r_in_vld;
    logic [1:0]                  r_action;
    logic                        r_port_up, r_port_down, r_star_up, r_star_down;
    logic                        r_slow, r_pov, r_port_stop, r_star_stop;
    logic signed [POS_WIDTH-1:0] r_port_pos, r_star_pos;

    // Output register.
    logic                      r_out_vld;
    logic signed [POWER_W-1:0] r_port_power, r_star_power;
    logic                      r_drive, r_solenoid, r_zero_enc, r_homed;

    logic                      in_take;
    logic                      advance;
    logic [GAIN_W-1:0]         mag;
    logic signed [POWER_W-1:0] port_gated, star_gated;
    logic                      apply;
    t_action                   action;
    t_ratchet_req              req;
    t_ratchet_stat             stat;

    // The middle stage moves whenever the output register is free or being read.
    assign advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_limit    <= TOP_LIMIT_RST;
            r_bottom_limit <= BOTTOM_LIMIT_RST;
            r_slow_gain    <= SLOW_GAIN_RST;
            r_delay        <= DELAY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOP_LIMIT:    r_top_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_BOTTOM_LIMIT: r_bottom_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SLOW_GAIN:    r_slow_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_DELAY:        r_delay        <= i_cfg_data[TIMER_W-1:0];
                default:          r_delay        <= r_delay;
            endcase
        end
    end

    // Input register: valid bit under reset, payload loaded on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action    <= i_action;
            r_port_up   <= i_port_up_button;
            r_port_down <= i_port_down_button;
            r_star_up   <= i_star_up_button;
            r_star_down <= i_star_down_button;
            r_slow      <= i_slow_mode;
            r_pov       <= i_pov_pressed;
            r_port_stop <= i_port_on_stop;
            r_star_stop <= i_star_on_stop;
            r_port_pos  <= i_port_position;
            r_star_pos  <= i_star_position;
        end
    end

    // Slow mode uses the configured gain, saturated at full power.
    always_comb begin
        if (!r_slow) begin
            mag = FULL_POWER;
        end else if (r_slow_gain > FULL_POWER) begin
            mag = FULL_POWER;
        end else begin
            mag = r_slow_gain;
        end
    end

    cri_power_gate #(.POS_WIDTH(POS_WIDTH)) u_port_gate (
        .i_up           (r_port_up),
        .i_down         (r_port_down),
        .i_mag          (mag),
        .i_on_stop      (r_port_stop),
        .i_position     (r_port_pos),
        .i_homed        (stat.homed_cur),
        .i_top_limit    (r_top_limit),
        .i_bottom_limit (r_bottom_limit),
        .o_power        (port_gated)
    );

    cri_power_gate #(.POS_WIDTH(POS_WIDTH)) u_star_gate (
        .i_up           (r_star_up),
        .i_down         (r_star_down),
        .i_mag          (mag),
        .i_on_stop      (r_star_stop),
        .i_position     (r_star_pos),
        .i_homed        (stat.homed_cur),
        .i_top_limit    (r_top_limit),
        .i_bottom_limit (r_bottom_limit),
        .o_power        (star_gated)
    );

    assign action        = t_action'(r_action);
    assign req.fire      = advance;
    assign req.action    = action;
    assign req.pov       = r_pov;
    assign req.power_nz  = (port_gated != '0) || (star_gated != '0);
    assign req.both_stop = r_port_stop && r_star_stop;

    cri_ratchet u_ratchet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_delay (r_delay),
        .o_stat  (stat)
    );

    // Gated power reaches the motors only on a control sample that drives.
    assign apply = (action == ACT_CTRL) && !stat.hold && stat.drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_port_power <= apply ? port_gated : '0;
            r_star_power <= apply ? star_gated : '0;
            r_drive      <= stat.drive;
            r_solenoid   <= stat.solenoid;
            r_zero_enc   <= stat.zero_enc;
            r_homed      <= stat.homed_next;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_port_power    = r_port_power;
    assign o_star_power    = r_star_power;
    assign o_drive_update  = r_drive;
    assign o_solenoid_open = r_solenoid;
    assign o_zero_encoders = r_zero_enc;
    assign o_homed         = r_homed;

endmodule
`default_nettype wire
